// File: design/distance_constraint_project_top_assert.svh
`ifndef DISTANCE_CONSTRAINT_PROJECT_TOP_ASSERT_SVH
`define DISTANCE_CONSTRAINT_PROJECT_TOP_ASSERT_SVH

// checked while out of reset
`define DCP_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// checked in every cycle, reset included
`define DCP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) (ante) |=> (cons)) else $error(msg);

`endif

// File: design/dcp_pkg.sv
package dcp_pkg;

    localparam int SQRT_STAGES = 34;
    localparam int LAM_STAGES  = 50;
    localparam int DIR_STAGES  = 17;

    typedef enum logic {
        CFG_COMPLIANCE = 1'b0,
        CFG_MIN_DENOM  = 1'b1
    } cfg_index_t;

    typedef struct packed {
        logic [11:0]      idx1;
        logic [11:0]      idx2;
        logic [2:0][31:0] p1;
        logic [2:0][31:0] p2;
        logic [30:0]      w1;
        logic [30:0]      w2;
        logic [30:0]      rest;
    } in_t;

    typedef struct packed {
        logic [11:0]      idx1;
        logic [11:0]      idx2;
        logic [2:0][31:0] p1;
        logic [2:0][31:0] p2;
        logic [30:0]      w1;
        logic [30:0]      w2;
        logic [30:0]      rest;
        logic [2:0]       neg;
        logic [2:0][32:0] mag;
        logic [32:0]      denom;
        logic             den_ok;
    } item_t;

    typedef struct packed {
        item_t            item;
        logic [33:0]      dlen;
        logic             c_neg;
        logic             apply;
        logic [49:0]      num;
        logic [33:0]      lrem;
        logic [49:0]      lam;
        logic [2:0][34:0] nrem;
        logic [2:0][16:0] dir;
    } div_t;

    typedef struct packed {
        logic [11:0]      idx1;
        logic [11:0]      idx2;
        logic [2:0][31:0] np1;
        logic [2:0][31:0] np2;
        logic             applied;
    } res_t;

endpackage

// File: design/dcp_front.sv
module dcp_front (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           en,
    input  logic           in_valid,
    input  dcp_pkg::in_t   in_data,
    input  logic [30:0]    compliance,
    input  logic [30:0]    min_denom,
    output logic           out_valid,
    output dcp_pkg::item_t out_item,
    output logic [67:0]    out_sum
);
    import dcp_pkg::*;

    item_t             f1_next, f1_reg, f2_reg, f3_reg;
    logic [2:0][65:0]  sq_next, sq_reg;
    logic [67:0]       sum_next, sum_reg;
    logic [2:0]        v_reg;

    always_comb begin
        logic [32:0] d;
        f1_next.idx1  = in_data.idx1;
        f1_next.idx2  = in_data.idx2;
        f1_next.p1    = in_data.p1;
        f1_next.p2    = in_data.p2;
        f1_next.w1    = in_data.w1;
        f1_next.w2    = in_data.w2;
        f1_next.rest  = in_data.rest;
        f1_next.denom = {2'b00, in_data.w1} + {2'b00, in_data.w2} + {2'b00, compliance};
        f1_next.den_ok = (f1_next.denom != 33'd0) && (f1_next.denom >= {2'b00, min_denom});
        for (int k = 0; k < 3; k++) begin
            d = {in_data.p1[k][31], in_data.p1[k]} - {in_data.p2[k][31], in_data.p2[k]};
            f1_next.neg[k] = d[32];
            f1_next.mag[k] = d[32] ? 33'(-d) : d;
        end
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            sq_next[k] = 66'(f1_reg.mag[k]) * 66'(f1_reg.mag[k]);
        end
        sum_next = 68'(sq_reg[0]) + 68'(sq_reg[1]) + 68'(sq_reg[2]);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= {v_reg[1:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            f1_reg  <= f1_next;
            f2_reg  <= f1_reg;
            sq_reg  <= sq_next;
            f3_reg  <= f2_reg;
            sum_reg <= sum_next;
        end
    end

    assign out_valid = v_reg[2];
    assign out_item  = f3_reg;
    assign out_sum   = sum_reg;

endmodule

// File: design/dcp_sqrt.sv
module dcp_sqrt (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           en,
    input  logic           in_valid,
    input  dcp_pkg::item_t in_item,
    input  logic [67:0]    in_sum,
    output logic           out_valid,
    output dcp_pkg::item_t out_item,
    output logic [33:0]    out_dist
);
    import dcp_pkg::*;

    typedef struct packed {
        item_t       item;
        logic [67:0] rad;
        logic [35:0] rem;
        logic [33:0] root;
    } sq_t;

    sq_t                    st_in   [SQRT_STAGES];
    sq_t                    st_next [SQRT_STAGES];
    sq_t                    st_reg  [SQRT_STAGES];
    logic [SQRT_STAGES-1:0] v_reg;

    assign st_in[0] = '{item: in_item, rad: in_sum, rem: '0, root: '0};

    for (genvar j = 0; j < SQRT_STAGES; j++) begin : g_bit
        if (j > 0) begin : g_link
            assign st_in[j] = st_reg[j-1];
        end

        always_comb begin
            logic [37:0] tmp;
            logic [37:0] trial;
            logic        ge;
            tmp   = {st_in[j].rem, st_in[j].rad[67:66]};
            trial = {2'b00, st_in[j].root, 2'b01};
            ge    = tmp >= trial;
            st_next[j].item = st_in[j].item;
            st_next[j].rad  = {st_in[j].rad[65:0], 2'b00};
            st_next[j].rem  = ge ? 36'(tmp - trial) : tmp[35:0];
            st_next[j].root = {st_in[j].root[32:0], ge};
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                st_reg[j] <= st_next[j];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= {v_reg[SQRT_STAGES-2:0], in_valid};
        end
    end

    assign out_valid = v_reg[SQRT_STAGES-1];
    assign out_item  = st_reg[SQRT_STAGES-1].item;
    assign out_dist  = st_reg[SQRT_STAGES-1].root;

endmodule

// File: design/dcp_div.sv
module dcp_div (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           en,
    input  logic           in_valid,
    input  dcp_pkg::item_t in_item,
    input  logic [33:0]    in_dist,
    output logic           out_valid,
    output dcp_pkg::div_t  out_div
);
    import dcp_pkg::*;

    div_t                  d0_next, d0_reg;
    div_t                  st_in   [LAM_STAGES];
    div_t                  st_next [LAM_STAGES];
    div_t                  st_reg  [LAM_STAGES];
    logic [LAM_STAGES:0]   v_reg;

    always_comb begin
        logic [33:0] rest_w;
        rest_w        = {3'b000, in_item.rest};
        d0_next.item  = in_item;
        d0_next.dlen  = in_dist;
        d0_next.c_neg = in_dist < rest_w;
        d0_next.apply = (in_dist != 34'd0) && in_item.den_ok;
        d0_next.num   = d0_next.c_neg ? {rest_w - in_dist, 16'h0000}
                                      : {in_dist - rest_w, 16'h0000};
        d0_next.lrem  = '0;
        d0_next.lam   = '0;
        for (int k = 0; k < 3; k++) begin
            d0_next.nrem[k] = {2'b00, in_item.mag[k]};
        end
        d0_next.dir   = '0;
    end

    assign st_in[0] = d0_reg;

    for (genvar j = 0; j < LAM_STAGES; j++) begin : g_step
        if (j > 0) begin : g_link
            assign st_in[j] = st_reg[j-1];
        end

        always_comb begin
            logic [33:0] t;
            logic        ge;
            logic [34:0] nt;
            logic        nge;
            st_next[j] = st_in[j];
            t  = {st_in[j].lrem[32:0], st_in[j].num[LAM_STAGES-1-j]};
            ge = t >= {1'b0, st_in[j].item.denom};
            st_next[j].lrem = ge ? t - {1'b0, st_in[j].item.denom} : t;
            st_next[j].lam  = {st_in[j].lam[48:0], ge};
            for (int k = 0; k < 3; k++) begin
                nt  = (j == 0) ? st_in[j].nrem[k] : {st_in[j].nrem[k][33:0], 1'b0};
                nge = nt >= {1'b0, st_in[j].dlen};
                if (j < DIR_STAGES) begin
                    st_next[j].nrem[k] = nge ? nt - {1'b0, st_in[j].dlen} : nt;
                    st_next[j].dir[k]  = {st_in[j].dir[k][15:0], nge};
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                st_reg[j] <= st_next[j];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            d0_reg <= d0_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= {v_reg[LAM_STAGES-1:0], in_valid};
        end
    end

    assign out_valid = v_reg[LAM_STAGES];
    assign out_div   = st_reg[LAM_STAGES-1];

endmodule

// File: design/dcp_update.sv
module dcp_update (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          en,
    input  logic          in_valid,
    input  dcp_pkg::div_t in_div,
    output logic          out_valid,
    output dcp_pkg::res_t out_res
);
    import dcp_pkg::*;

    localparam logic [47:0] SCALE_CLAMP = 48'h8000_0000_0000;

    function automatic logic [31:0] sat32(input logic [49:0] v);
        logic [31:0] r;
        if (v[49:31] == {19{v[49]}}) begin
            r = v[31:0];
        end else if (v[49]) begin
            r = 32'h8000_0000;
        end else begin
            r = 32'h7FFF_FFFF;
        end
        return r;
    endfunction

    function automatic logic [47:0] scale_of(input logic [48:0] top, input logic [62:0] bot);
        logic [47:0] s;
        s = {1'b0, top[30:0], 16'h0000} + {1'b0, bot[62:16]};
        if (top[48:31] != 18'd0 || s > SCALE_CLAMP) begin
            s = SCALE_CLAMP;
        end
        return s;
    endfunction

    div_t             u1_reg, u2_reg, u3_reg;
    logic [48:0]      top1_reg, top2_reg;
    logic [62:0]      bot1_reg, bot2_reg;
    logic [47:0]      s1_reg, s2_reg;
    logic [2:0][47:0] st1_next, st2_next, st1_reg, st2_reg;
    res_t             res_next, res_reg;
    logic [3:0]       v_reg;

    always_comb begin
        logic [64:0] pr1;
        logic [64:0] pr2;
        for (int k = 0; k < 3; k++) begin
            pr1 = 65'(s1_reg) * 65'(u2_reg.dir[k]);
            pr2 = 65'(s2_reg) * 65'(u2_reg.dir[k]);
            st1_next[k] = pr1[63:16];
            st2_next[k] = pr2[63:16];
        end
    end

    always_comb begin
        logic [49:0] p1e;
        logic [49:0] p2e;
        logic [49:0] a1;
        logic [49:0] a2;
        logic        pos;
        res_next.idx1    = u3_reg.item.idx1;
        res_next.idx2    = u3_reg.item.idx2;
        res_next.applied = u3_reg.apply;
        for (int k = 0; k < 3; k++) begin
            p1e = {{18{u3_reg.item.p1[k][31]}}, u3_reg.item.p1[k]};
            p2e = {{18{u3_reg.item.p2[k][31]}}, u3_reg.item.p2[k]};
            a1  = {2'b00, st1_reg[k]};
            a2  = {2'b00, st2_reg[k]};
            pos = (u3_reg.c_neg == u3_reg.item.neg[k]);
            if (u3_reg.apply) begin
                res_next.np1[k] = sat32(pos ? p1e - a1 : p1e + a1);
                res_next.np2[k] = sat32(pos ? p2e + a2 : p2e - a2);
            end else begin
                res_next.np1[k] = u3_reg.item.p1[k];
                res_next.np2[k] = u3_reg.item.p2[k];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            u1_reg   <= in_div;
            top1_reg <= 49'(in_div.lam[49:32]) * 49'(in_div.item.w1);
            bot1_reg <= 63'(in_div.lam[31:0]) * 63'(in_div.item.w1);
            top2_reg <= 49'(in_div.lam[49:32]) * 49'(in_div.item.w2);
            bot2_reg <= 63'(in_div.lam[31:0]) * 63'(in_div.item.w2);
            u2_reg   <= u1_reg;
            s1_reg   <= scale_of(top1_reg, bot1_reg);
            s2_reg   <= scale_of(top2_reg, bot2_reg);
            u3_reg   <= u2_reg;
            st1_reg  <= st1_next;
            st2_reg  <= st2_next;
            res_reg  <= res_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= {v_reg[2:0], in_valid};
        end
    end

    assign out_valid = v_reg[3];
    assign out_res   = res_reg;

endmodule

// File: design/distance_constraint_project_top.sv
// Throughput: one item per cycle; the pipeline holds as a whole while a
// result waits. The square root and divider chains have 34 and 50 stages.
// Reset (aresetn, synchronous, active low) empties the pipeline and sets
// compliance to 0 and min_denominator to 1.
`include "distance_constraint_project_top_assert.svh"

module distance_constraint_project_top (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    // first_index, second_index, first_x/y/z, second_x/y/z,
    // first_weight, second_weight, rest_length, zero pad
    input  logic [311:0]  s_tdata,
    output logic          m_tvalid,
    input  logic          m_tready,
    // out_first_index, out_second_index, new_first_x/y/z, new_second_x/y/z
    output logic [215:0]  m_tdata,
    // applied
    output logic [0:0]    m_tuser,
    input  logic          cfg_wr_en,
    input  logic [0:0]    cfg_wr_index,
    input  logic [30:0]   cfg_wr_data
);
    import dcp_pkg::*;

    logic [30:0] compliance_reg, min_denom_reg;
    logic        en;
    in_t         in_data;
    logic        f_valid, q_valid, d_valid, u_valid;
    item_t       f_item, q_item;
    logic [67:0] f_sum;
    logic [33:0] q_dist;
    div_t        d_div;
    res_t        u_res;

    assign en       = !u_valid || m_tready;
    assign s_tready = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            compliance_reg <= 31'd0;
            min_denom_reg  <= 31'd1;
        end else if (cfg_wr_en) begin
            unique case (cfg_index_t'(cfg_wr_index))
                CFG_COMPLIANCE: compliance_reg <= cfg_wr_data;
                CFG_MIN_DENOM:  min_denom_reg  <= cfg_wr_data;
            endcase
        end
    end

    always_comb begin
        in_data.idx1  = s_tdata[11:0];
        in_data.idx2  = s_tdata[23:12];
        in_data.p1[0] = s_tdata[55:24];
        in_data.p1[1] = s_tdata[87:56];
        in_data.p1[2] = s_tdata[119:88];
        in_data.p2[0] = s_tdata[151:120];
        in_data.p2[1] = s_tdata[183:152];
        in_data.p2[2] = s_tdata[215:184];
        in_data.w1    = s_tdata[246:216];
        in_data.w2    = s_tdata[277:247];
        in_data.rest  = s_tdata[308:278];
    end

    dcp_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .en         (en),
        .in_valid   (s_tvalid),
        .in_data    (in_data),
        .compliance (compliance_reg),
        .min_denom  (min_denom_reg),
        .out_valid  (f_valid),
        .out_item   (f_item),
        .out_sum    (f_sum)
    );

    dcp_sqrt u_sqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (f_valid),
        .in_item   (f_item),
        .in_sum    (f_sum),
        .out_valid (q_valid),
        .out_item  (q_item),
        .out_dist  (q_dist)
    );

    dcp_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (q_valid),
        .in_item   (q_item),
        .in_dist   (q_dist),
        .out_valid (d_valid),
        .out_div   (d_div)
    );

    dcp_update u_update (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (d_valid),
        .in_div    (d_div),
        .out_valid (u_valid),
        .out_res   (u_res)
    );

    assign m_tvalid = u_valid;
    assign m_tdata  = {u_res.np2[2], u_res.np2[1], u_res.np2[0],
                       u_res.np1[2], u_res.np1[1], u_res.np1[0],
                       u_res.idx2, u_res.idx1};
    assign m_tuser  = u_res.applied;

    `DCP_ASSERT_NOW(a_stall_blocks_input, m_tvalid && !m_tready, !s_tready, "input taken while output stalled")
    `DCP_ASSERT_NEXT(a_reset_empties, !aresetn, !m_tvalid, "result valid right after reset")

endmodule

// File: tb/sv/distance_constraint_project_top_test.sv
module distance_constraint_project_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    import dcp_pkg::*;

    localparam longint unsigned SCALE_LIMIT = 64'd1 << 47;
    localparam int LATENCY = 92;
    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct {
        logic [11:0] idx1;
        logic [11:0] idx2;
        logic [31:0] p1 [3];
        logic [31:0] p2 [3];
        logic [30:0] w1;
        logic [30:0] w2;
        logic [30:0] rest;
    } constraint_t;

    typedef struct {
        logic [11:0] idx1;
        logic [11:0] idx2;
        logic [31:0] np1 [3];
        logic [31:0] np2 [3];
        logic        applied;
    } projection_t;

    class projection_scoreboard;
        projection_t pending[$];
        logic [30:0] compliance;
        logic [30:0] min_denom;
        int          errors;
        int          checked;
        int          applied_count;

        function new();
            compliance = 0;
            min_denom = 1;
            errors = 0;
            checked = 0;
            applied_count = 0;
        endfunction

        static function logic [31:0] saturate(longint v);
            if (v > 64'sd2147483647) v = 64'sd2147483647;
            if (v < -64'sd2147483648) v = -64'sd2147483648;
            return v[31:0];
        endfunction

        function void note_input(constraint_t c);
            projection_t r;
            longint d [3];
            longint unsigned m [3];
            logic [127:0] sq;
            logic [127:0] cand;
            longint unsigned dlen, denom, cmag, lam, s1, s2, n, st1, st2;
            logic [127:0] prod;
            bit c_neg, pos;
            longint sg1, sg2;
            sq = 0;
            for (int k = 0; k < 3; k++) begin
                d[k] = longint'($signed(c.p1[k])) - longint'($signed(c.p2[k]));
                m[k] = d[k] < 0 ? -d[k] : d[k];
                sq += 128'(m[k]) * 128'(m[k]);
            end
            dlen = 0;
            for (int b = 33; b >= 0; b--) begin
                cand = 128'(dlen | (64'd1 << b));
                if (cand * cand <= sq) dlen = dlen | (64'd1 << b);
            end
            denom = 64'(c.w1) + 64'(c.w2) + 64'(compliance);
            r.idx1 = c.idx1;
            r.idx2 = c.idx2;
            r.applied = dlen != 0 && denom != 0 && denom >= 64'(min_denom);
            if (r.applied) begin
                c_neg = dlen < 64'(c.rest);
                cmag = c_neg ? 64'(c.rest) - dlen : dlen - 64'(c.rest);
                lam = (cmag << 16) / denom;
                prod = (128'(lam) * 128'(c.w1)) >> 16;
                s1 = prod > 128'(SCALE_LIMIT) ? SCALE_LIMIT : prod[63:0];
                prod = (128'(lam) * 128'(c.w2)) >> 16;
                s2 = prod > 128'(SCALE_LIMIT) ? SCALE_LIMIT : prod[63:0];
                for (int k = 0; k < 3; k++) begin
                    n = (m[k] << 16) / dlen;
                    prod = (128'(s1) * 128'(n)) >> 16;
                    st1 = prod[63:0];
                    prod = (128'(s2) * 128'(n)) >> 16;
                    st2 = prod[63:0];
                    pos = (c_neg == (d[k] < 0));
                    sg1 = pos ? longint'(st1) : -longint'(st1);
                    sg2 = pos ? longint'(st2) : -longint'(st2);
                    r.np1[k] = saturate(longint'($signed(c.p1[k])) - sg1);
                    r.np2[k] = saturate(longint'($signed(c.p2[k])) + sg2);
                end
            end else begin
                for (int k = 0; k < 3; k++) begin
                    r.np1[k] = c.p1[k];
                    r.np2[k] = c.p2[k];
                end
            end
            pending.push_back(r);
        endfunction

        function void compare(string name, logic [31:0] exp_v, logic [31:0] act_v);
            if (exp_v !== act_v) begin
                $error("%s mismatch: expected %h actual %h", name, exp_v, act_v);
                errors++;
            end
        endfunction

        function void check_result(logic [215:0] data, logic flag);
            projection_t e;
            if (pending.size() == 0) begin
                $error("result with no expectation: %h", data);
                errors++;
                return;
            end
            e = pending.pop_front();
            checked++;
            if (e.applied) applied_count++;
            compare("out_first_index", 32'(e.idx1), 32'(data[11:0]));
            compare("out_second_index", 32'(e.idx2), 32'(data[23:12]));
            for (int k = 0; k < 3; k++) begin
                compare($sformatf("new_first_%s", k == 0 ? "x" : k == 1 ? "y" : "z"),
                        e.np1[k], data[24 + 32*k +: 32]);
                compare($sformatf("new_second_%s", k == 0 ? "x" : k == 1 ? "y" : "z"),
                        e.np2[k], data[120 + 32*k +: 32]);
            end
            compare("applied", 32'(e.applied), 32'(flag));
        endfunction
    endclass

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [311:0] s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [215:0] m_tdata;
    logic [0:0]   m_tuser;
    logic         cfg_wr_en;
    logic [0:0]   cfg_wr_index;
    logic [30:0]  cfg_wr_data;

    projection_scoreboard board;
    bit  sink_idle_ok;
    bit  hold_sink;
    int  idle_cycles;
    int  sent;

    distance_constraint_project_top i_dut (
        .aclk, .aresetn, .s_tvalid, .s_tready, .s_tdata, .m_tvalid, .m_tready,
        .m_tdata, .m_tuser, .cfg_wr_en, .cfg_wr_index, .cfg_wr_data
    );

    initial begin
        aclk = 0;
        forever #1 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) board.check_result(m_tdata, m_tuser[0]);
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !aresetn) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("distance_constraint_project_top_test failed");
                $finish;
            end
        end
    end

    // receiver: random stalls, or a long hold when asked
    initial begin
        m_tready = 0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (hold_sink) begin
                m_tready <= 0;
                repeat (400) @(negedge aclk);
                hold_sink = 0;
            end
            if (sink_idle_ok && $urandom_range(0, 7) == 0) begin
                m_tready <= 0;
                repeat ($urandom_range(1, 9)) @(negedge aclk);
            end
            m_tready <= 1;
        end
    end

    task automatic write_reg(cfg_index_t idx, logic [30:0] value);
        @(negedge aclk);
        cfg_wr_en <= 1;
        cfg_wr_index <= idx;
        cfg_wr_data <= value;
        @(negedge aclk);
        cfg_wr_en <= 0;
        if (idx == CFG_COMPLIANCE) board.compliance = value;
        else board.min_denom = value;
    endtask

    task automatic drain();
        while (board.pending.size() != 0) @(negedge aclk);
        repeat (LATENCY + 8) @(negedge aclk);
    endtask

    // called right after a negedge; leaves s_tvalid high on return
    task automatic send(constraint_t c, bit gaps);
        logic [311:0] pk;
        if (gaps && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 0;
            repeat ($urandom_range(1, 10)) @(negedge aclk);
        end
        pk = 0;
        pk[11:0] = c.idx1;
        pk[23:12] = c.idx2;
        for (int k = 0; k < 3; k++) begin
            pk[24 + 32*k +: 32] = c.p1[k];
            pk[120 + 32*k +: 32] = c.p2[k];
        end
        pk[246:216] = c.w1;
        pk[277:247] = c.w2;
        pk[308:278] = c.rest;
        s_tdata <= pk;
        s_tvalid <= 1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        board.note_input(c);
        sent++;
        @(negedge aclk);
    endtask

    task automatic stop_sending();
        s_tvalid <= 0;
    endtask

    function automatic logic [31:0] rand_coord(int mode);
        case (mode)
            0: return $urandom();
            1: return 32'($signed($urandom_range(0, 32'h000A_0000)) - 32'sh0005_0000);
            2: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            default: return 32'($signed($urandom_range(0, 32'h0400_0000)) - 32'sh0200_0000);
        endcase
    endfunction

    function automatic constraint_t random_item();
        constraint_t c;
        int mode;
        mode = $urandom_range(0, 9);
        c.idx1 = 12'($urandom());
        c.idx2 = 12'($urandom());
        for (int k = 0; k < 3; k++) begin
            c.p1[k] = rand_coord(mode < 2 ? 0 : mode < 7 ? 1 : mode < 9 ? 3 : 2);
            c.p2[k] = ($urandom_range(0, 15) == 0) ? c.p1[k] :
                      rand_coord(mode < 2 ? 0 : mode < 7 ? 1 : mode < 9 ? 3 : 2);
        end
        case ($urandom_range(0, 3))
            0: begin c.w1 = 31'($urandom()); c.w2 = 31'($urandom()); end
            1: begin c.w1 = 0; c.w2 = 31'($urandom_range(0, 32'h0002_0000)); end
            default: begin
                c.w1 = 31'($urandom_range(0, 32'h0002_0000));
                c.w2 = 31'($urandom_range(0, 32'h0002_0000));
            end
        endcase
        c.rest = $urandom_range(0, 1) ? 31'($urandom()) : 31'($urandom_range(0, 32'h0008_0000));
        return c;
    endfunction

    function automatic constraint_t make_item(logic [31:0] a, logic [31:0] b,
            logic [30:0] w1, logic [30:0] w2, logic [30:0] rest);
        constraint_t c;
        c.idx1 = 12'($urandom());
        c.idx2 = 12'($urandom());
        for (int k = 0; k < 3; k++) begin
            c.p1[k] = a;
            c.p2[k] = b;
        end
        c.w1 = w1;
        c.w2 = w2;
        c.rest = rest;
        return c;
    endfunction

    initial begin
        constraint_t c;
        board = new();
        aresetn = 0;
        s_tvalid = 0;
        s_tdata = 0;
        cfg_wr_en = 0;
        cfg_wr_index = CFG_COMPLIANCE;
        cfg_wr_data = 0;
        sink_idle_ok = 0;
        hold_sink = 0;
        sent = 0;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1;
        @(negedge aclk);

        // directed: extremes and the zero-distance and zero-denominator skip paths, reset register values
        send(make_item(32'h7FFF_FFFF, 32'h8000_0000, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 0), 0);
        send(make_item(32'h8000_0000, 32'h7FFF_FFFF, 31'h0001_0000, 31'h7FFF_FFFF, 0), 0);
        send(make_item(32'h0001_0000, 32'h0001_0000, 31'h0001_0000, 31'h0001_0000,
                       31'h0001_0000), 0);
        send(make_item(32'h0000_0001, 32'h0000_0000, 31'h0001_0000, 31'h0001_0000, 0), 0);
        send(make_item(32'h0001_0000, 32'h0000_0000, 0, 0, 31'h0001_0000), 0);
        c = make_item(32'h0000_0000, 32'h0000_0000, 31'h0001_0000, 31'h0000_8000, 0);
        c.p1[0] = 32'h0003_0000;
        c.p1[1] = 32'h0004_0000;
        c.rest = 31'h0005_0000;
        send(c, 0);
        c.rest = 31'h7FFF_FFFF;
        send(c, 0);
        c.rest = 0;
        c.idx1 = 12'hFFF;
        c.idx2 = 12'h000;
        send(c, 0);
        send(make_item(32'h7FFF_FFFF, 32'h8000_0000, 31'h7FFF_FFFF, 0, 31'h7FFF_FFFF), 0);
        send(make_item(32'h0000_8000, 32'hFFFF_8000, 1, 1, 0), 0);
        stop_sending();
        drain();

        write_reg(CFG_COMPLIANCE, 31'h7FFF_FFFF);
        write_reg(CFG_MIN_DENOM, 0);
        send(make_item(32'h0001_0000, 32'h0000_0000, 0, 0, 0), 0);
        send(make_item(32'h8000_0000, 32'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 0), 0);
        stop_sending();
        drain();
        write_reg(CFG_COMPLIANCE, 0);
        send(make_item(32'h0001_0000, 32'h0000_0000, 0, 0, 0), 0);
        stop_sending();
        drain();
        write_reg(CFG_MIN_DENOM, 31'h7FFF_FFFF);
        send(make_item(32'h0001_0000, 32'h0000_0000, 31'h4000_0000, 31'h3FFF_FFFF, 0), 0);
        send(make_item(32'h0001_0000, 32'h0000_0000, 31'h4000_0000, 31'h4000_0000, 0), 0);
        stop_sending();
        drain();

        // random phases over several register settings
        sink_idle_ok = 1;
        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0: begin write_reg(CFG_COMPLIANCE, 0); write_reg(CFG_MIN_DENOM, 1); end
                1: begin
                    write_reg(CFG_COMPLIANCE, 31'($urandom_range(0, 32'h0001_0000)));
                    write_reg(CFG_MIN_DENOM, 31'($urandom_range(0, 32'h0001_8000)));
                end
                2: begin write_reg(CFG_COMPLIANCE, 31'h7FFF_FFFF); write_reg(CFG_MIN_DENOM, 0); end
                3: begin
                    write_reg(CFG_COMPLIANCE, 31'($urandom()));
                    write_reg(CFG_MIN_DENOM, 31'($urandom()));
                end
                default: begin
                    write_reg(CFG_COMPLIANCE, 31'($urandom_range(0, 32'h0000_4000)));
                    write_reg(CFG_MIN_DENOM, 31'($urandom_range(0, 32'h0000_4000)));
                end
            endcase
            if (phase == 1) hold_sink = 1;
            if (phase == 5) sink_idle_ok = 0;
            for (int i = 0; i < 190; i++) send(random_item(), phase != 5 && !hold_sink);
            stop_sending();
            drain();
        end

        $display("Sent %0d constraints over 10 register settings; %0d results checked, %0d applied.",
                 sent, board.checked, board.applied_count);
        if (board.errors == 0 && board.pending.size() == 0)
            $display("distance_constraint_project_top_test passed");
        else
            $display("distance_constraint_project_top_test failed");
        $finish;
    end
endmodule
